/* rtl/crc8fp_pkg.sv */
package crc8fp_pkg;

   localparam logic [7:0] MAX_PAYLOAD = 8'd64;
   localparam logic [7:0] SYNC_FIRST  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND = 8'h55;
   // CRC-8/MAXIM, reflected form of 0x31
   localparam logic [7:0] CRC_POLY    = 8'h8C;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // queue between front and back; depth must be a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   localparam logic [1:0] KIND_REJECT    = 2'd0;
   localparam logic [1:0] KIND_HEADER    = 2'd1;
   localparam logic [1:0] KIND_DATA      = 2'd2;
   localparam logic [1:0] KIND_DATA_LAST = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;   // type on a header, payload byte on data
      logic [7:0] len;
      logic [7:0] crc;     // running CRC after this item
   } entry_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* rtl/crc8fp_req_if.sv */
interface crc8fp_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] pkt_type;
   logic [7:0] frame_len;
   logic [7:0] data_byte;

   modport source (output valid, output command, output pkt_type, output frame_len,
                   output data_byte, input ready);
   modport sink (input valid, input command, input pkt_type, input frame_len,
                 input data_byte, output ready);
endinterface

/* rtl/crc8fp_rsp_if.sv */
interface crc8fp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_end;
   logic       rejected;

   modport source (output valid, output out_byte, output frame_end, output rejected,
                   input ready);
   modport sink (input valid, input out_byte, input frame_end, input rejected,
                 output ready);
endinterface

/* rtl/crc8_frame_packer_top.sv */
// channel | dir | handshake    | payload
// req     | in  | valid/ready  | command, pkt_type, frame_len, data_byte
// rsp     | out | valid/ready  | out_byte, frame_end, rejected
//
// One item accepted per cycle while the four-entry queue has room.
// A payload item in an open frame yields one or two bytes (byte, then CRC on the last), one
// per cycle while rsp is ready; a start item yields four or five bytes, a rejection one byte,
// all through one output register, so the output byte rate sets the sustained item rate.
// Reset is synchronous: closes any frame, empties the queue, drops the output byte.
// A stalled rsp holds its byte; req stalls only when the queue is full.
module crc8_frame_packer_top
   import crc8fp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   crc8fp_req_if.sink    req,
   crc8fp_rsp_if.source  rsp
);

   logic      push;
   entry_type push_entry;
   logic      queue_full;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   crc8fp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   crc8fp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   crc8fp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

/* rtl/crc8fp_front.sv */
module crc8fp_front
   import crc8fp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   crc8fp_req_if.sink        req,
   input  logic              queue_full,
   output logic              push,
   output entry_type         push_entry
);

   logic [7:0] crc_ff, crc_in;
   logic [7:0] left_ff, left_in;
   logic       open_ff, open_in;
   logic       accept;
   logic [7:0] crc_hdr;
   logic [7:0] crc_data;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   assign crc_hdr  = crc8_update(crc8_update(8'h00, req.pkt_type), req.frame_len);
   assign crc_data = crc8_update(crc_ff, req.data_byte);

   always_comb begin
      crc_in           = crc_ff;
      left_in          = left_ff;
      open_in          = open_ff;
      push             = 1'b0;
      push_entry.kind  = KIND_REJECT;
      push_entry.value = req.data_byte;
      push_entry.len   = req.frame_len;
      push_entry.crc   = crc_data;
      if (accept) begin
         if (req.command == CMD_START) begin
            push = 1'b1;
            if (req.frame_len > MAX_PAYLOAD) begin
               // abandon any open frame
               crc_in  = 8'h00;
               left_in = 8'h00;
               open_in = 1'b0;
            end else begin
               push_entry.kind  = KIND_HEADER;
               push_entry.value = req.pkt_type;
               push_entry.crc   = crc_hdr;
               crc_in           = crc_hdr;
               left_in          = req.frame_len;
               open_in          = (req.frame_len != 8'h00);
            end
         end else if (open_ff) begin
            // payload bytes outside a frame are dropped
            push    = 1'b1;
            crc_in  = crc_data;
            left_in = left_ff - 8'd1;
            if (left_ff == 8'd1) begin
               push_entry.kind = KIND_DATA_LAST;
               open_in         = 1'b0;
            end else begin
               push_entry.kind = KIND_DATA;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= 8'h00;
         left_ff <= 8'h00;
         open_ff <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         left_ff <= left_in;
         open_ff <= open_in;
      end
   end

   a_open_has_bytes: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> (left_ff != 8'h00) && (left_ff <= MAX_PAYLOAD))
      else $error("open frame with bad byte count");

endmodule

/* rtl/crc8fp_queue.sv */
module crc8fp_queue
   import crc8fp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      // pointers wrap on their own since the depth is a power of two
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> !pop)
      else $error("pop from empty queue");

endmodule

/* rtl/crc8fp_back.sv */
module crc8fp_back
   import crc8fp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  entry_type  head_entry,
   output logic       pop,
   crc8fp_rsp_if.source rsp
);

   localparam logic [2:0] POS_SYNC1 = 3'd0;
   localparam logic [2:0] POS_SYNC2 = 3'd1;
   localparam logic [2:0] POS_TYPE  = 3'd2;
   localparam logic [2:0] POS_LEN   = 3'd3;
   localparam logic [2:0] POS_CRC   = 3'd4;

   logic [2:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       end_ff, end_in;
   logic       rej_ff, rej_in;
   logic       load;
   logic [7:0] sel_byte;
   logic       sel_end;
   logic       sel_rej;
   logic       sel_last;

   assign load = head_valid && (!valid_ff || rsp.ready);

   always_comb begin
      sel_byte = head_entry.value;
      sel_end  = 1'b0;
      sel_rej  = 1'b0;
      sel_last = 1'b1;
      case (head_entry.kind)
         KIND_REJECT: begin
            sel_byte = 8'h00;
            sel_end  = 1'b1;
            sel_rej  = 1'b1;
         end
         KIND_HEADER: begin
            sel_last = 1'b0;
            case (pos_ff)
               POS_SYNC1: sel_byte = SYNC_FIRST;
               POS_SYNC2: sel_byte = SYNC_SECOND;
               POS_TYPE:  sel_byte = head_entry.value;
               POS_LEN: begin
                  sel_byte = head_entry.len;
                  sel_last = (head_entry.len != 8'h00);
               end
               default: begin
                  sel_byte = head_entry.crc;
                  sel_end  = 1'b1;
                  sel_last = 1'b1;
               end
            endcase
         end
         KIND_DATA: sel_byte = head_entry.value;
         default: begin
            // last payload byte, then the CRC trailer
            if (pos_ff == POS_SYNC1) begin
               sel_byte = head_entry.value;
               sel_last = 1'b0;
            end else begin
               sel_byte = head_entry.crc;
               sel_end  = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      rej_in   = rej_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = sel_byte;
         end_in   = sel_end;
         rej_in   = sel_rej;
         if (sel_last) begin
            pop    = 1'b1;
            pos_in = POS_SYNC1;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_SYNC1;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
      rej_ff  <= rej_in;
   end

   assign rsp.valid     = valid_ff;
   assign rsp.out_byte  = byte_ff;
   assign rsp.frame_end = end_ff;
   assign rsp.rejected  = rej_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_CRC)
      else $error("byte position out of range");

   a_reject_form: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rej_ff) |-> (end_ff && byte_ff == 8'h00))
      else $error("malformed rejection");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import crc8fp_pkg::*;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int ITEMS_PER_PHASE = 110;

   typedef struct packed {
      logic       command;
      logic [7:0] pkt_type;
      logic [7:0] frame_len;
      logic [7:0] data_byte;
   } cmd_item_type;

   typedef struct packed {
      logic [7:0] value;
      logic       frame_end;
      logic       rejected;
   } framed_byte_type;

   logic clock;
   logic reset;

   crc8fp_req_if req_ch ();
   crc8fp_rsp_if rsp_ch ();

   crc8_frame_packer_top u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   cmd_item_type    pending_cmds[$];
   framed_byte_type expected_bytes[$];

   // frame state of the predictor
   logic [7:0] frame_crc;
   logic [7:0] frame_left;
   logic       frame_active;

   // frame state as seen by the stimulus generator
   logic gen_open;

   int send_idle_pct;
   int recv_stall_pct;
   int error_count;
   int idle_cycles;
   int items_accepted;
   int bytes_checked;
   int frames_closed;
   int frames_rejected;
   int strays_dropped;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] maxim_crc_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ b[i];
         c  = c >> 1;
         if (fb) c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   task automatic push_expected(input logic [7:0] v, input logic e, input logic r);
      framed_byte_type fb;
      fb.value     = v;
      fb.frame_end = e;
      fb.rejected  = r;
      expected_bytes.push_back(fb);
   endtask

   task automatic predict_frame_bytes(input cmd_item_type it);
      if (it.command == CMD_START) begin
         if (it.frame_len > MAX_PAYLOAD) begin
            frame_active = 1'b0;
            frame_left   = 8'd0;
            frame_crc    = 8'd0;
            push_expected(8'd0, 1'b1, 1'b1);
            frames_rejected++;
         end else begin
            frame_crc = maxim_crc_step(maxim_crc_step(8'd0, it.pkt_type), it.frame_len);
            push_expected(SYNC_FIRST, 1'b0, 1'b0);
            push_expected(SYNC_SECOND, 1'b0, 1'b0);
            push_expected(it.pkt_type, 1'b0, 1'b0);
            push_expected(it.frame_len, 1'b0, 1'b0);
            if (it.frame_len == 8'd0) begin
               push_expected(frame_crc, 1'b1, 1'b0);
               frame_active = 1'b0;
               frame_left   = 8'd0;
               frames_closed++;
            end else begin
               frame_active = 1'b1;
               frame_left   = it.frame_len;
            end
         end
      end else if (!frame_active) begin
         strays_dropped++;
      end else begin
         frame_crc = maxim_crc_step(frame_crc, it.data_byte);
         push_expected(it.data_byte, 1'b0, 1'b0);
         frame_left = frame_left - 8'd1;
         if (frame_left == 8'd0) begin
            push_expected(frame_crc, 1'b1, 1'b0);
            frame_active = 1'b0;
            frames_closed++;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("MISMATCH %s: got 0x%02h, want 0x%02h at %0t", what, got, want, $time);
      error_count++;
   endtask

   task automatic push_start(input logic [7:0] ptype, input logic [7:0] plen);
      cmd_item_type it;
      it.command   = CMD_START;
      it.pkt_type  = ptype;
      it.frame_len = plen;
      it.data_byte = 8'($urandom_range(0, 255));
      pending_cmds.push_back(it);
   endtask

   task automatic push_data(input logic [7:0] d);
      cmd_item_type it;
      it.command   = CMD_DATA;
      it.pkt_type  = 8'($urandom_range(0, 255));
      it.frame_len = 8'($urandom_range(0, 255));
      it.data_byte = d;
      pending_cmds.push_back(it);
   endtask

   // mostly complete frames; some cut short, some rejected, some stray bytes between
   task automatic run_random_phase(input int target);
      int count;
      int pick;
      int plen;
      int nsent;
      count = 0;
      while (count < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 70 || pick >= 95) begin
            if (pick >= 95) plen = int'(MAX_PAYLOAD);
            else begin
               pick = $urandom_range(0, 9);
               if (pick < 7) plen = $urandom_range(0, 8);
               else if (pick < 9) plen = $urandom_range(9, 40);
               else plen = $urandom_range(41, MAX_PAYLOAD);
            end
            push_start(8'($urandom_range(0, 255)), 8'(plen));
            for (int i = 0; i < plen; i++) push_data(8'($urandom_range(0, 255)));
            count += plen + 1;
            gen_open = 1'b0;
         end else if (pick < 80) begin
            plen  = $urandom_range(2, 20);
            nsent = $urandom_range(0, plen - 1);
            push_start(8'($urandom_range(0, 255)), 8'(plen));
            for (int i = 0; i < nsent; i++) push_data(8'($urandom_range(0, 255)));
            count += nsent + 1;
            gen_open = 1'b1;
         end else if (pick < 88 || gen_open) begin
            push_start(8'($urandom_range(0, 255)),
                       8'($urandom_range(MAX_PAYLOAD + 1, 255)));
            count++;
            gen_open = 1'b0;
         end else begin
            // dropped by the block, so not counted
            nsent = $urandom_range(1, 3);
            for (int i = 0; i < nsent; i++) push_data(8'($urandom_range(0, 255)));
         end
      end
      while (pending_cmds.size() != 0) @(posedge clock);
   endtask

   // driver: advance to the next item once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_ch.valid     <= 1'b1;
            req_ch.command   <= pending_cmds[0].command;
            req_ch.pkt_type  <= pending_cmds[0].pkt_type;
            req_ch.frame_len <= pending_cmds[0].frame_len;
            req_ch.data_byte <= pending_cmds[0].data_byte;
            void'(pending_cmds.pop_front());
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // monitor: check output bytes, then predict from the accepted item
   always @(posedge clock) begin
      framed_byte_type exp_byte;
      cmd_item_type    seen;
      if (reset) begin
         frame_crc    = 8'd0;
         frame_left   = 8'd0;
         frame_active = 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
               report_mismatch("unexpected byte", rsp_ch.out_byte, 8'd0);
            end else begin
               exp_byte = expected_bytes.pop_front();
               if (rsp_ch.out_byte !== exp_byte.value)
                  report_mismatch("out_byte", rsp_ch.out_byte, exp_byte.value);
               if (rsp_ch.frame_end !== exp_byte.frame_end)
                  report_mismatch("frame_end", {7'd0, rsp_ch.frame_end},
                                  {7'd0, exp_byte.frame_end});
               if (rsp_ch.rejected !== exp_byte.rejected)
                  report_mismatch("rejected", {7'd0, rsp_ch.rejected},
                                  {7'd0, exp_byte.rejected});
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seen.command   = req_ch.command;
            seen.pkt_type  = req_ch.pkt_type;
            seen.frame_len = req_ch.frame_len;
            seen.data_byte = req_ch.data_byte;
            items_accepted++;
            predict_frame_bytes(seen);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d bytes still expected",
                     idle_cycles, expected_bytes.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.command   = CMD_START;
      req_ch.pkt_type  = 8'd0;
      req_ch.frame_len = 8'd0;
      req_ch.data_byte = 8'd0;
      rsp_ch.ready     = 1'b0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      error_count      = 0;
      items_accepted   = 0;
      bytes_checked    = 0;
      frames_closed    = 0;
      frames_rejected  = 0;
      strays_dropped   = 0;
      gen_open         = 1'b0;

      // stray byte straight out of reset
      push_data(8'h3C);
      // zero-length frames at both type extremes
      push_start(8'h00, 8'd0);
      push_start(8'hFF, 8'd0);
      push_start(8'hA5, 8'd1);
      push_data(8'hFF);
      push_start(8'h5A, 8'd2);
      push_data(8'h00);
      push_data(8'h80);
      // lengths just above the limit and at the top of the field
      push_start(8'h01, MAX_PAYLOAD + 8'd1);
      push_start(8'hFE, 8'd255);
      // new start abandons an open frame
      push_start(8'h12, 8'd3);
      push_data(8'hAA);
      push_start(8'h7E, 8'd1);
      push_data(8'h55);
      // rejection while a frame is open, then a byte with no frame
      push_start(8'h33, 8'd4);
      push_data(8'h01);
      push_start(8'h80, 8'd200);
      push_data(8'h77);
      push_start(8'hC3, 8'd0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      run_random_phase(ITEMS_PER_PHASE);
      send_idle_pct  = 88;
      recv_stall_pct = 0;
      run_random_phase(ITEMS_PER_PHASE);
      send_idle_pct  = 0;
      recv_stall_pct = 88;
      run_random_phase(ITEMS_PER_PHASE);
      send_idle_pct  = 14;
      recv_stall_pct = 14;
      run_random_phase(ITEMS_PER_PHASE);

      while (pending_cmds.size() != 0 || req_ch.valid) @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d items and %0d output bytes under four idle/stall mixes",
               items_accepted, bytes_checked);
      $display("frames closed %0d, rejected %0d, stray bytes dropped %0d",
               frames_closed, frames_rejected, strays_dropped);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/crc8fp_pkg.sv
rtl/crc8fp_req_if.sv
rtl/crc8fp_rsp_if.sv
rtl/crc8fp_front.sv
rtl/crc8fp_queue.sv
rtl/crc8fp_back.sv
rtl/crc8_frame_packer_top.sv
dv/tb_top.sv
